// File: hdl/ble_pkg.sv
package ble_pkg;

  // Store geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
  localparam int DATA_W   = 32;
  localparam int FIDX_W   = 4;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_END   = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_END   = 3'd4,
    MODE_DEL_AT    = 3'd5,
    MODE_SEARCH    = 3'd6,
    MODE_NONE      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_SRCH
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   value;
    logic        [FIDX_W-1:0]   index;
  } result_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } seq_stat_t;

endpackage

// File: hdl/ble_in_if.sv
interface ble_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] item_value;
  logic signed [7:0]  position;

  modport source (output valid, output mode, output item_value, output position,
                  input ready);
  modport sink (input valid, input mode, input item_value, input position,
                output ready);
endinterface

// File: hdl/ble_out_if.sv
interface ble_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [3:0]         found_index;

  modport source (output valid, output status, output result_value,
                  output found_index, input ready);
  modport sink (input valid, input status, input result_value,
                input found_index, output ready);
endinterface

// File: hdl/ble_ram.sv
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ble_seq.sv
module ble_seq (
  input  logic                clk,
  input  logic                rst,
  ble_in_if.sink              req,
  output logic                res_valid,
  output ble_pkg::result_t    res,
  input  logic                res_ready,
  output ble_pkg::seq_stat_t  stat,
  output logic                ram_we,
  output logic [ble_pkg::IDX_W-1:0]  ram_waddr,
  output logic [ble_pkg::DATA_W-1:0] ram_wdata,
  output logic [ble_pkg::IDX_W-1:0]  ram_raddr,
  input  logic [ble_pkg::DATA_W-1:0] ram_rdata
);
  import ble_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  op_t                op, op_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [DATA_W-1:0]  val, val_next;
  logic [IDX_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   rd_left, rd_left_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pend_addr, pend_addr_next;
  result_t            res_q, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    op        <= op_next;
    idx       <= idx_next;
    val       <= val_next;
    rd_ptr    <= rd_ptr_next;
    rd_left   <= rd_left_next;
    pend_addr <= pend_addr_next;
    res_q     <= res_next;
  end

  always_comb begin
    mode_t            m;
    logic             neg;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] tgt;
    status_t          st;
    op_t              op_sel;
    logic             go;
    logic             issue;

    m       = mode_t'(req.mode);
    neg     = req.position[7];
    pos_ext = CMP_W'(req.position[6:0]);
    cnt_ext = CMP_W'(count);
    full    = (count == CNT_W'(CAPACITY));
    empty   = (count == '0);
    tgt     = '0;
    st      = ST_OK;
    op_sel  = OP_INS;
    go      = 1'b0;
    issue   = 1'b0;

    state_next     = state;
    count_next     = count;
    op_next        = op;
    idx_next       = idx;
    val_next       = val;
    rd_ptr_next    = rd_ptr;
    rd_left_next   = rd_left;
    pend_next      = 1'b0;
    pend_addr_next = rd_ptr;
    res_next       = res_q;
    req.ready      = 1'b0;
    res_valid      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = rd_ptr;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        unique case (m) inside
          MODE_INS_FRONT, MODE_INS_END: begin
            if (full) begin
              st = ST_FULL;
            end else begin
              go  = 1'b1;
              tgt = (m == MODE_INS_FRONT) ? '0 : count;
            end
          end
          MODE_INS_AT: begin
            if (neg || (pos_ext > cnt_ext)) begin
              st = ST_BAD_INDEX;
            end else if (full) begin
              st = ST_FULL;
            end else begin
              go  = 1'b1;
              tgt = pos_ext[CNT_W-1:0];
            end
          end
          MODE_DEL_FRONT, MODE_DEL_END: begin
            op_sel = OP_DEL;
            if (empty) begin
              st = ST_EMPTY;
            end else begin
              go  = 1'b1;
              tgt = (m == MODE_DEL_FRONT) ? '0 : count - CNT_W'(1);
            end
          end
          MODE_DEL_AT: begin
            op_sel = OP_DEL;
            if (neg) begin
              st = ST_BAD_INDEX;
            end else if (empty) begin
              st = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              st = ST_BAD_INDEX;
            end else begin
              go  = 1'b1;
              tgt = pos_ext[CNT_W-1:0];
            end
          end
          MODE_SEARCH: begin
            op_sel = OP_SRCH;
            if (empty) begin
              st = ST_EMPTY;
            end else begin
              go = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (req.valid) begin
          res_next.status = st;
          res_next.value  = '0;
          res_next.index  = '0;
          if (go) begin
            op_next      = op_sel;
            idx_next     = tgt[IDX_W-1:0];
            val_next     = req.item_value;
            rd_left_next = count - tgt;
            rd_ptr_next  = (op_sel == OP_INS) ? IDX_W'(count - CNT_W'(1))
                                              : tgt[IDX_W-1:0];
            state_next   = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (rd_left != '0) begin
          issue        = 1'b1;
          rd_left_next = rd_left - CNT_W'(1);
          rd_ptr_next  = (op == OP_INS) ? rd_ptr - IDX_W'(1) : rd_ptr + IDX_W'(1);
        end
        pend_next = issue;

        if (pend) begin
          unique case (op)
            OP_INS: begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr + IDX_W'(1);
            end
            OP_DEL: begin
              if (pend_addr == idx) begin
                res_next.value = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr - IDX_W'(1);
              end
            end
            default: begin
            end
          endcase
        end

        if (pend && (op == OP_SRCH) && (ram_rdata == val)) begin
          res_next.status = ST_OK;
          res_next.index  = FIDX_W'(pend_addr);
          state_next      = S_DONE;
        end else if ((rd_left == '0) && !pend) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        unique case (op)
          OP_INS: begin
            ram_we     = 1'b1;
            ram_waddr  = idx;
            ram_wdata  = val;
            count_next = count + CNT_W'(1);
          end
          OP_DEL: begin
            count_next = count - CNT_W'(1);
          end
          default: begin
            res_next.status = ST_NOT_FOUND;
          end
        endcase
        state_next = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res        = res_q;
  assign stat.idle  = (state == S_IDLE);
  assign stat.count = count;

endmodule

// File: hdl/bounded_circular_list_engine.sv
// Ordered list of up to CAPACITY (16) signed 32-bit values held in one
// single-port-write, single-port-read RAM with a registered read.
// Each request beat carries a mode (insert front, insert end, insert at a
// position, delete front, delete end, delete at a position, search), a value
// and a position, and produces exactly one response beat with a status, the
// removed value of a successful delete, and the first matching index of a
// successful search. Requests are handled one at a time. An operation that
// fails its checks (empty list, full store or bad index) goes straight to
// the response without touching the RAM, as does a request with the unused
// mode code, which is answered with an OK status. A successful operation
// walks the RAM, one entry per cycle through its read port, then drains the
// read pipeline and finishes the update; a search that finds a match goes
// straight to the response. The RAM needs no clearing after reset: only
// entries below the element count are ever read. The response sits in an
// output register, so a new request can be taken while an earlier response
// is still waiting to be picked up.
module bounded_circular_list_engine (
  input  logic      clk,
  input  logic      rst,
  ble_in_if.sink    req,
  ble_out_if.source rsp
);
  import ble_pkg::*;

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  seq_stat_t         stat;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Output holding register.
  logic    ob_valid;
  result_t ob;

  // The sequencer owns the element count and every RAM access.
  ble_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // The list itself. Entry i holds element i for every i below the count.
  ble_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A finished result moves into the output register whenever that register
  // is empty or is being drained in the same cycle.
  assign res_ready = !ob_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      ob_valid <= 1'b1;
    end else if (rsp.ready) begin
      ob_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      ob <= res;
    end
  end

  assign rsp.valid        = ob_valid;
  assign rsp.status       = ob.status;
  assign rsp.result_value = ob.value;
  assign rsp.found_index  = ob.index;

  // In the cycle after a request is taken the sequencer is busy and takes no new request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while the previous one was still starting");

  // The element count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // A full-store report only comes from a full store.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FULL) |-> (stat.count == CNT_W'(CAPACITY)))
    else $error("store full reported with room left");

  // An empty-list report only comes from an empty list.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_EMPTY) |-> (stat.count == '0))
    else $error("list empty reported with elements present");

endmodule
